// ===== rtl/core/lpcd_pkg.sv =====
package lpcd_pkg;

  // Field widths of the command stream
  localparam int unsigned CodeW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned ByteW = 8;

  // Default number of length bytes per frame header
  localparam int unsigned LengthBytesDefault = 2;

  // Reset values and the padding byte
  localparam logic [LenW-1:0]  MaxPayloadReset = 16'd64;
  localparam logic [CodeW-1:0] CodeReset       = 8'hFF;
  localparam logic [ByteW-1:0] PadByte         = 8'h00;

  // One result of the parser
  typedef struct packed {
    logic [CodeW-1:0] command_code;
    logic [LenW-1:0]  payload_length;
    logic             has_payload;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  byte_index;
    logic             frame_last;
    logic             overflow;
  } lpcd_res_t;

endpackage

// ===== rtl/core/lpcd_parser.sv =====
module lpcd_parser #(
  parameter int unsigned LENGTH_BYTES = lpcd_pkg::LengthBytesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lpcd_pkg::LenW-1:0]   max_payload_i,
  input  logic                        byte_valid_i,
  input  logic [lpcd_pkg::ByteW-1:0]  byte_i,
  output logic                        res_valid_o,
  output lpcd_pkg::lpcd_res_t         res_o
);
  import lpcd_pkg::*;

  localparam int unsigned LenCntW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
  localparam logic [LenCntW-1:0] LenCntLast = LenCntW'(LENGTH_BYTES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEN,
    ST_DATA
  } state_e;

  state_e               state_q, state_d;
  logic [CodeW-1:0]     code_q, code_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [LenCntW-1:0]   len_cnt_q, len_cnt_d;
  logic [LenW-1:0]      idx_q, idx_d;

  logic [LenW-1:0]      len_merged;
  logic                 data_last;
  logic                 data_ovf;

  // Merge the incoming length byte at its little-endian position
  assign len_merged = len_q | (LenW'(byte_i) << {len_cnt_q, 3'b000});
  assign data_last  = ({1'b0, idx_q} + 17'd1) == {1'b0, len_q};
  assign data_ovf   = idx_q >= max_payload_i;

  // Next state and result for one accepted byte
  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    len_d       = len_q;
    len_cnt_d   = len_cnt_q;
    idx_d       = idx_q;
    res_valid_o = 1'b0;
    res_o       = '{command_code: code_q, payload_length: len_q, has_payload: 1'b0,
                    payload_byte: '0, byte_index: '0, frame_last: 1'b0,
                    overflow: 1'b0};
    if (byte_valid_i) begin
      unique case (state_q)
        ST_LEN: begin
          len_d     = len_merged;
          len_cnt_d = len_cnt_q + LenCntW'(1);
          if (len_cnt_q == LenCntLast) begin
            if (len_merged == '0) begin
              // Empty frame: one result, no payload
              res_valid_o         = 1'b1;
              res_o.frame_last    = 1'b1;
              state_d             = ST_IDLE;
            end else begin
              state_d = ST_DATA;
              idx_d   = '0;
            end
          end
        end
        ST_DATA: begin
          res_valid_o        = 1'b1;
          res_o.has_payload  = 1'b1;
          res_o.payload_byte = byte_i;
          res_o.byte_index   = idx_q;
          res_o.frame_last   = data_last;
          res_o.overflow     = data_ovf;
          idx_d              = idx_q + LenW'(1);
          if (data_last) begin
            state_d = ST_IDLE;
          end
        end
        default: begin
          // Idle: skip padding, otherwise open a frame
          if (byte_i != PadByte) begin
            code_d    = byte_i;
            len_d     = '0;
            len_cnt_d = '0;
            state_d   = ST_LEN;
          end
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      code_q    <= CodeReset;
      len_q     <= '0;
      len_cnt_q <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      code_q    <= code_d;
      len_q     <= len_d;
      len_cnt_q <= len_cnt_d;
      idx_q     <= idx_d;
    end
  end

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.has_payload) |-> (res_o.frame_last && res_o.payload_length == '0))
    else $error("empty-frame result without last mark or with nonzero length");

  a_ovf_needs_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.overflow) |-> res_o.has_payload)
    else $error("overflow flagged on a result without payload");

  a_data_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> (len_q != '0))
    else $error("payload phase entered with zero length");

  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.has_payload) |-> (res_o.byte_index < res_o.payload_length))
    else $error("payload index beyond declared length");

endmodule

// ===== rtl/core/length_prefixed_command_deframer.sv =====
// A byte that yields a result shows on the master side in the cycle after acceptance.
// Throughput: one byte per cycle while the output register is empty or draining; the parser
// state steps once per byte; the one-deep output register refills in the cycle it drains.
// Reset: asynchronous, active low; parser returns to idle, command id reads 255,
// max_payload_bytes returns to 64 and the output register empties.
module length_prefixed_command_deframer #(
  parameter int unsigned LENGTH_BYTES = lpcd_pkg::LengthBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: max_payload_bytes
  input  logic                          cfg_we_i,
  input  logic [lpcd_pkg::LenW-1:0]     cfg_wdata_i,
  // Slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  // Master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] command_code, [23:8] payload_length, [31:24] payload_byte, [47:32] byte_index
  output logic [47:0]                   m_axis_tdata,
  output logic                          m_axis_tlast,   // frame_last
  output logic [1:0]                    m_axis_tuser    // [0] has_payload, [1] overflow
);
  import lpcd_pkg::*;

  logic [LenW-1:0] max_payload_q;
  logic            in_fire;
  logic            res_valid;
  lpcd_res_t       res;
  logic            out_valid_q;
  lpcd_res_t       out_q;

  // Take a byte whenever the output slot is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_wdata_i;
    end
  end

  lpcd_parser #(
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_payload_i (max_payload_q),
    .byte_valid_i  (in_fire),
    .byte_i        (s_axis_tdata[ByteW-1:0]),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Output register: load a new result or drop the taken one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= in_fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.byte_index, out_q.payload_byte,
                          out_q.payload_length, out_q.command_code};
  assign m_axis_tlast  = out_q.frame_last;
  assign m_axis_tuser  = {out_q.overflow, out_q.has_payload};

endmodule

// ===== tb/tb_length_prefixed_command_deframer.sv =====
module tb_length_prefixed_command_deframer;
  import lpcd_pkg::*;

  localparam int unsigned CycleLimit   = 8_000_000;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxGap       = 12;
  localparam logic [1:0]  LenBytes     = 2'(LengthBytesDefault);

  // Parser phases of the predictor
  typedef enum logic [1:0] {
    WaitCode   = 2'd0,
    GetLength  = 2'd1,
    GetPayload = 2'd2
  } parse_state_e;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [LenW-1:0]  cfg_wdata_i   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;   // [7:0] rx_byte
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // [7:0] command_code, [23:8] payload_length, [31:24] payload_byte, [47:32] byte_index
  logic [47:0]      m_axis_tdata;
  logic             m_axis_tlast;         // frame_last
  logic [1:0]       m_axis_tuser;         // [0] has_payload, [1] overflow

  length_prefixed_command_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Byte stream waiting for the driver and results the deframer owes us
  logic [7:0]   pending_bytes[$];
  lpcd_res_t    expected_results[$];
  int unsigned  bytes_queued     = 0;
  int unsigned  bytes_accepted   = 0;
  int unsigned  results_seen     = 0;
  int unsigned  frames_seen      = 0;
  int unsigned  empty_frames     = 0;
  int unsigned  overflows_seen   = 0;
  int unsigned  capacity_writes  = 0;
  int unsigned  mismatch_count   = 0;
  int unsigned  cycle_count      = 0;

  // Traffic shaping knobs, set per phase
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  int unsigned  hold_req   = 0;
  int unsigned  hold_ack   = 0;
  int unsigned  tx_gap     = 0;
  int unsigned  rx_gap     = 0;

  // Deframer state as the predictor tracks it
  parse_state_e     parse_state;
  logic [CodeW-1:0] frame_code;
  logic [LenW-1:0]  frame_len;
  logic [1:0]       len_bytes_got;
  logic [LenW-1:0]  payload_count;
  logic [LenW-1:0]  model_capacity;

  task automatic reset_parser_model();
    parse_state    = WaitCode;
    frame_code     = CodeReset;
    frame_len      = '0;
    len_bytes_got  = '0;
    payload_count  = '0;
    model_capacity = MaxPayloadReset;
  endtask

  // Advance the parser by one accepted byte and queue any result it yields
  task automatic predict_byte(input logic [7:0] rx);
    lpcd_res_t res;
    res = '0;
    res.command_code = frame_code;
    case (parse_state)
      GetLength: begin
        if (len_bytes_got < 2'd2)
          frame_len = frame_len | (LenW'(rx) << (8 * len_bytes_got));
        len_bytes_got = len_bytes_got + 2'd1;
        if (len_bytes_got == LenBytes) begin
          if (frame_len == '0) begin
            res.payload_length = '0;
            res.frame_last     = 1'b1;
            expected_results.push_back(res);
            parse_state = WaitCode;
          end else begin
            parse_state   = GetPayload;
            payload_count = '0;
          end
        end
      end
      GetPayload: begin
        res.payload_length = frame_len;
        res.has_payload    = 1'b1;
        res.payload_byte   = rx;
        res.byte_index     = payload_count;
        res.frame_last     = ({1'b0, payload_count} + 17'd1) == {1'b0, frame_len};
        res.overflow       = payload_count >= model_capacity;
        expected_results.push_back(res);
        payload_count = payload_count + 16'd1;
        if (res.frame_last)
          parse_state = WaitCode;
      end
      default: begin
        if (rx != PadByte) begin
          frame_code    = rx;
          parse_state   = GetLength;
          len_bytes_got = '0;
          frame_len     = '0;
        end
      end
    endcase
  endtask

  // Sender: predict on each accepted transaction, then offer the next byte after its gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tx_gap = 0;
      reset_parser_model();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_byte(s_axis_tdata);
        bytes_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_bytes.pop_front();
          tx_gap = tx_idle_on ? $urandom_range(0, MaxGap) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare one result transaction against the oldest expectation
  task automatic check_result();
    lpcd_res_t want;
    results_seen++;
    if (m_axis_tlast) frames_seen++;
    if (!m_axis_tuser[0]) empty_frames++;
    if (m_axis_tuser[1]) overflows_seen++;
    if (expected_results.size() == 0) begin
      $error("unexpected result: tdata %h tlast %b tuser %b",
             m_axis_tdata, m_axis_tlast, m_axis_tuser);
      mismatch_count++;
    end else begin
      want = expected_results.pop_front();
      check_field("command_code", want.command_code, m_axis_tdata[7:0]);
      check_field("payload_length", want.payload_length, m_axis_tdata[23:8]);
      check_field("has_payload", want.has_payload, m_axis_tuser[0]);
      check_field("payload_byte", want.payload_byte, m_axis_tdata[31:24]);
      check_field("byte_index", want.byte_index, m_axis_tdata[47:32]);
      check_field("frame_last", want.frame_last, m_axis_tlast);
      check_field("overflow", want.overflow, m_axis_tuser[1]);
    end
  endtask

  // Receiver: check each transaction, may stall after it, honor long hold-off requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result();
        rx_gap = rx_idle_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        rx_gap   = LongHold;
      end
      if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic push_byte(input logic [7:0] value);
    pending_bytes.push_back(value);
    bytes_queued++;
  endtask

  // Frame header followed by random payload
  task automatic push_frame(input logic [7:0] code, input logic [15:0] len);
    push_byte(code);
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    for (int unsigned i = 0; i < len; i++)
      push_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 85) return 16'($urandom_range(1, 16));
    if (r < 97) return 16'($urandom_range(17, 80));
    return 16'($urandom_range(256, 300));
  endfunction

  // Hold until every byte is taken and every result has come back
  task automatic wait_idle();
    while (bytes_accepted != bytes_queued || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    model_capacity = value;
    capacity_writes++;
  endtask

  // Mostly well-formed frames, some padding, some frames cut short or overrun
  task automatic random_traffic(input int unsigned n);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    logic [15:0] flen;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        flen = pick_length();
        push_frame(8'($urandom_range(1, 255)), flen);
        sent += 3 + flen;
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 4)) push_byte(PadByte);
      end else begin
        len = $urandom_range(1, 40);
        cut = $urandom_range(1, len);
        push_byte(8'($urandom_range(1, 255)));
        push_byte(8'(len));
        push_byte(8'h00);
        if ($urandom_range(0, 1) == 0) begin
          // short payload; trailing zeros get swallowed as the missing bytes
          repeat (len - cut) push_byte(8'($urandom_range(0, 255)));
          repeat (cut) push_byte(PadByte);
        end else begin
          // overrun; excess zeros land in idle as padding
          repeat (len) push_byte(8'($urandom_range(0, 255)));
          repeat (cut) push_byte(PadByte);
        end
        sent += 3 + len;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: padding, empty frame, byte extremes, capacity boundary
    push_byte(PadByte);
    push_byte(PadByte);
    push_frame(8'h01, 16'd0);
    push_byte(8'hFF);
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h7E);
    push_byte(8'h03);
    push_byte(8'h00);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h55);
    write_capacity(16'd1);
    push_byte(8'hA5);
    push_byte(8'h02);
    push_byte(8'h00);
    push_byte(8'h11);
    push_byte(8'h22);

    // Random phases across capacity settings and idling patterns
    random_traffic(300);
    write_capacity(16'hFFFF);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_traffic(250);
    write_capacity(16'($urandom_range(1, 24)));
    rx_idle_on = 1'b1;
    random_traffic(250);

    // Long output stall with the sender running flat out
    write_capacity(16'd8);
    rx_idle_on = 1'b0;
    hold_req++;
    random_traffic(200);

    write_capacity(16'($urandom_range(1, 65535)));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    random_traffic(200);

    // One longer frame, no idling
    write_capacity(16'hFFFF);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    push_frame(8'hFF, 16'd120);

    write_capacity(MaxPayloadReset);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    random_traffic(100);
    wait_idle();
    repeat (20) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      mismatch_count++;
    end
    $display("Sent %0d bytes; checked %0d results over %0d frames (%0d empty).",
             bytes_accepted, results_seen, frames_seen, empty_frames);
    $display("%0d capacity writes, %0d bytes flagged over capacity, one long output stall.",
             capacity_writes, overflows_seen);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/lpcd_pkg.sv
rtl/core/lpcd_parser.sv
rtl/core/length_prefixed_command_deframer.sv
tb/tb_length_prefixed_command_deframer.sv
